// ----- hdl/sfpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Sonar frame parse/average package
// Widths, character codes and types shared by the front parser, the frame
// queue and the averaging back end.
// ----------------------------------------------------------------------------
package sfpa_pkg;

  localparam int BYTE_W     = 8;
  localparam int VALUE_W    = 14;   // one frame value in millimetres, up to 9999
  localparam int SUM_W      = 22;   // batch total in millimetres
  localparam int CNT_W      = 8;    // measurement count and frames done
  localparam int DIV_W      = 12;   // count times ten, up to 2550
  localparam int AVG_W      = 10;
  localparam int CHAR_CNT_W = 3;    // saturates at FRAME_LEN + 1
  localparam int STEP_W     = $clog2(SUM_W);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [BYTE_W-1:0]     CHAR_START = 8'h52;  // 'R'
  localparam logic [BYTE_W-1:0]     CHAR_END   = 8'h0D;  // carriage return
  localparam logic [BYTE_W-1:0]     CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0]     CHAR_NINE  = 8'h39;
  localparam logic [CHAR_CNT_W-1:0] FRAME_LEN  = 3'd4;
  localparam logic [CNT_W-1:0]      COUNT_MAX  = 8'd255;
  localparam logic [CNT_W-1:0]      COUNT_RST  = 8'd1;
  localparam logic [AVG_W-1:0]      AVG_MAX    = 10'd999;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_OUTPUT
  } bk_state_t;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value_mm;
  } frame_t;

endpackage

// ----- hdl/sfpa_front.sv -----
// ----------------------------------------------------------------------------
// Sonar frame parser
// Hunts for the start character, collects the frame characters up to the
// carriage return and hands the value of every four-character frame on.
// ----------------------------------------------------------------------------
module sfpa_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          byte_accept,
  input  logic [sfpa_pkg::BYTE_W-1:0]   rx_byte,
  output sfpa_pkg::frame_t              frame_out
);

  logic                              in_frame_r, in_frame_nxt;
  logic [sfpa_pkg::CHAR_CNT_W-1:0]   char_count_r, char_count_nxt;
  logic [sfpa_pkg::VALUE_W-1:0]      frame_value_r, frame_value_nxt;
  logic                              digits_ended_r, digits_ended_nxt;
  logic                              is_digit;
  logic [sfpa_pkg::VALUE_W-1:0]      digit_val;
  logic [sfpa_pkg::VALUE_W-1:0]      value_x10;

  assign is_digit  = (rx_byte >= sfpa_pkg::CHAR_ZERO) && (rx_byte <= sfpa_pkg::CHAR_NINE);
  assign digit_val = sfpa_pkg::VALUE_W'(rx_byte - sfpa_pkg::CHAR_ZERO);
  assign value_x10 = (frame_value_r << 3) + (frame_value_r << 1);

  always_comb begin
    in_frame_nxt       = in_frame_r;
    char_count_nxt     = char_count_r;
    frame_value_nxt    = frame_value_r;
    digits_ended_nxt   = digits_ended_r;
    frame_out.valid    = 1'b0;
    frame_out.value_mm = frame_value_r;
    if (byte_accept) begin
      if (!in_frame_r) begin
        if (rx_byte == sfpa_pkg::CHAR_START) begin
          in_frame_nxt     = 1'b1;
          char_count_nxt   = '0;
          frame_value_nxt  = '0;
          digits_ended_nxt = 1'b0;
        end
      end else if (rx_byte != sfpa_pkg::CHAR_END) begin
        if (char_count_r < sfpa_pkg::FRAME_LEN) begin
          if (!digits_ended_r && is_digit) begin
            frame_value_nxt = value_x10 + digit_val;
          end else begin
            digits_ended_nxt = 1'b1;
          end
        end
        // The count stops one past the frame length, enough to mark it too long.
        if (char_count_r <= sfpa_pkg::FRAME_LEN) begin
          char_count_nxt = char_count_r + 1'b1;
        end
      end else begin
        in_frame_nxt     = 1'b0;
        frame_out.valid  = (char_count_r == sfpa_pkg::FRAME_LEN);
        char_count_nxt   = '0;
        frame_value_nxt  = '0;
        digits_ended_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r     <= 1'b0;
      char_count_r   <= '0;
      frame_value_r  <= '0;
      digits_ended_r <= 1'b0;
    end else begin
      in_frame_r     <= in_frame_nxt;
      char_count_r   <= char_count_nxt;
      frame_value_r  <= frame_value_nxt;
      digits_ended_r <= digits_ended_nxt;
    end
  end

endmodule

// ----- hdl/sfpa_fifo.sv -----
// ----------------------------------------------------------------------------
// Sonar frame queue
// A short first-in first-out queue of frame values between the parser and
// the averaging back end.
// ----------------------------------------------------------------------------
module sfpa_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [sfpa_pkg::VALUE_W-1:0]  push_data,
  input  logic                          pop,
  output logic                          full,
  output logic                          not_empty,
  output logic [sfpa_pkg::VALUE_W-1:0]  pop_data
);

  logic [sfpa_pkg::VALUE_W-1:0]    mem_r [sfpa_pkg::FIFO_DEPTH];
  logic [sfpa_pkg::FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [sfpa_pkg::FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [sfpa_pkg::FIFO_CNT_W-1:0] count_r, count_nxt;
  logic                            do_push, do_pop;

  assign full      = (count_r == sfpa_pkg::FIFO_CNT_W'(sfpa_pkg::FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == sfpa_pkg::FIFO_PTR_W'(sfpa_pkg::FIFO_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == sfpa_pkg::FIFO_PTR_W'(sfpa_pkg::FIFO_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- hdl/sfpa_back.sv -----
// ----------------------------------------------------------------------------
// Sonar frame averager
// Adds up frame values, and at the end of each batch divides the total by
// the count times ten, one quotient bit per cycle, into an output register.
// ----------------------------------------------------------------------------
module sfpa_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sfpa_pkg::CNT_W-1:0]    count_cfg,
  input  logic                          q_not_empty,
  input  logic [sfpa_pkg::VALUE_W-1:0]  q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sfpa_pkg::AVG_W-1:0]    out_average_cm
);

  sfpa_pkg::bk_state_t             state_r, state_nxt;
  logic [sfpa_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic [sfpa_pkg::CNT_W-1:0]      frames_r, frames_nxt;
  logic [sfpa_pkg::SUM_W-1:0]      quo_r, quo_nxt;      // dividend, shifted into quotient
  logic [sfpa_pkg::DIV_W-1:0]      divisor_r, divisor_nxt;
  logic [sfpa_pkg::DIV_W-1:0]      rem_r, rem_nxt;
  logic [sfpa_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [sfpa_pkg::AVG_W-1:0]      out_avg_r, out_avg_nxt;

  logic [sfpa_pkg::CNT_W-1:0]      eff_count;
  logic [sfpa_pkg::SUM_W-1:0]      sum_add;
  logic [sfpa_pkg::CNT_W-1:0]      frames_add;
  logic                            batch_done;
  logic [sfpa_pkg::DIV_W:0]        trial;
  logic                            trial_fits;
  logic                            last_step;
  logic                            out_free;
  logic [sfpa_pkg::AVG_W-1:0]      avg_sat;

  always_comb begin
    eff_count = count_cfg;
    if (count_cfg == '0) begin
      eff_count = sfpa_pkg::CNT_W'(1);
    end else if (count_cfg > sfpa_pkg::COUNT_MAX) begin
      eff_count = sfpa_pkg::COUNT_MAX;
    end
  end

  assign sum_add    = sum_r + sfpa_pkg::SUM_W'(q_data);
  assign frames_add = frames_r + 1'b1;
  assign batch_done = (frames_add >= eff_count);

  assign trial      = {rem_r, quo_r[sfpa_pkg::SUM_W-1]};
  assign trial_fits = (trial >= {1'b0, divisor_r});
  assign last_step  = (step_r == sfpa_pkg::STEP_W'(sfpa_pkg::SUM_W - 1));
  assign out_free   = !out_valid_r || out_ready;
  assign avg_sat    = (quo_r > sfpa_pkg::SUM_W'(sfpa_pkg::AVG_MAX)) ?
                      sfpa_pkg::AVG_MAX : quo_r[sfpa_pkg::AVG_W-1:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sfpa_pkg::BK_IDLE: begin
        if (q_not_empty && batch_done) begin
          state_nxt = sfpa_pkg::BK_DIVIDE;
        end
      end
      sfpa_pkg::BK_DIVIDE: begin
        if (last_step) begin
          state_nxt = sfpa_pkg::BK_OUTPUT;
        end
      end
      sfpa_pkg::BK_OUTPUT: begin
        if (out_free) begin
          state_nxt = sfpa_pkg::BK_IDLE;
        end
      end
      default: state_nxt = sfpa_pkg::BK_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    q_pop         = 1'b0;
    sum_nxt       = sum_r;
    frames_nxt    = frames_r;
    quo_nxt       = quo_r;
    divisor_nxt   = divisor_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    out_avg_nxt   = out_avg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      sfpa_pkg::BK_IDLE: begin
        q_pop = q_not_empty;
        if (q_not_empty) begin
          if (batch_done) begin
            quo_nxt     = sum_add;
            divisor_nxt = (sfpa_pkg::DIV_W'(eff_count) << 3) +
                          (sfpa_pkg::DIV_W'(eff_count) << 1);
            rem_nxt     = '0;
            step_nxt    = '0;
            sum_nxt     = '0;
            frames_nxt  = '0;
          end else begin
            sum_nxt    = sum_add;
            frames_nxt = frames_add;
          end
        end
      end
      sfpa_pkg::BK_DIVIDE: begin
        rem_nxt  = trial_fits ? sfpa_pkg::DIV_W'(trial - {1'b0, divisor_r}) :
                                trial[sfpa_pkg::DIV_W-1:0];
        quo_nxt  = {quo_r[sfpa_pkg::SUM_W-2:0], trial_fits};
        step_nxt = step_r + 1'b1;
      end
      sfpa_pkg::BK_OUTPUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = avg_sat;
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfpa_pkg::BK_IDLE;
      sum_r       <= '0;
      frames_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      frames_r    <= frames_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r     <= quo_nxt;
    divisor_r <= divisor_nxt;
    rem_r     <= rem_nxt;
    step_r    <= step_nxt;
    out_avg_r <= out_avg_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_average_cm = out_avg_r;

endmodule

// ----- hdl/sonar_frame_parse_average.sv -----
// ----------------------------------------------------------------------------
// Sonar frame parse and average
// Parses ASCII range frames from a serial byte stream and emits the batch
// average in centimetres.
//
//   Channel  Ports                                   Carries
//   in       in_valid, in_ready, in_rx_byte          one received serial byte
//   out      out_valid, out_ready, out_average_cm    one batch average, cm
//   cfg      cfg_wr_en, cfg_wr_data                  measurement count
//
// The parser takes one byte per cycle while the two-entry frame queue has
// room. The averager takes queued frames while idle; a frame that closes a
// batch goes through the one-bit-per-cycle divider and into the output
// register, which holds its item while out_ready is low; no frame is taken
// meanwhile, and the parser keeps going until the queue fills.
// Reset is synchronous and active low; the count resets to one.
// ----------------------------------------------------------------------------
module sonar_frame_parse_average (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sfpa_pkg::BYTE_W-1:0]   in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sfpa_pkg::AVG_W-1:0]    out_average_cm,
  input  logic                          cfg_wr_en,
  input  logic [sfpa_pkg::CNT_W-1:0]    cfg_wr_data
);

  logic [sfpa_pkg::CNT_W-1:0]     count_r;
  sfpa_pkg::frame_t               frame;
  logic                           q_full;
  logic                           q_not_empty;
  logic                           q_pop;
  logic [sfpa_pkg::VALUE_W-1:0]   q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= sfpa_pkg::COUNT_RST;
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  assign in_ready = !q_full;

  sfpa_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_accept (in_valid && in_ready),
    .rx_byte     (in_rx_byte),
    .frame_out   (frame)
  );

  sfpa_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (frame.valid),
    .push_data (frame.value_mm),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  sfpa_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .count_cfg      (count_r),
    .q_not_empty    (q_not_empty),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_average_cm (out_average_cm)
  );

  // A finished frame never meets a full queue, since bytes stop while it is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    frame.valid |-> !q_full)
    else $error("frame pushed into a full queue");

  // The average saturates.
  a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_average_cm <= sfpa_pkg::AVG_MAX))
    else $error("average above saturation limit");

  // A pop always follows a queue that held an entry.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("pop from an empty queue");

  // A new result appears only after the output register was free.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!out_valid || out_ready))
    else $error("result loaded over a waiting item");

endmodule
